FILE: rtl/core/rgb_to_hsv_converter_assert.svh
// Assertion macros for the RGB to HSV converter.
// Relies on clk and rst_n being in scope where a macro is used.
`ifndef RGB_TO_HSV_CONVERTER_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_ASSERT_SVH

// Implication checked at every clock edge outside reset
`define R2H_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that holds whenever a result item is presented
`define R2H_CHECK_OUT(label, cons, msg) \
    `R2H_CHECK(label, m_tvalid, cons, msg)

`endif

FILE: rtl/core/r2h_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// No dependencies.
package r2h_pkg;

    // Which channel holds the maximum (ties: red, then green)
    typedef enum logic [1:0] {
        SEL_RED,
        SEL_GREEN,
        SEL_BLUE
    } hue_sel_t;

    // Divider geometry: hue numerator 256*(num+(k+6)*delta), divisor 6*delta
    localparam int DIV_QUO_W = 9;
    localparam int HUE_NUM_W = 20;
    localparam int HUE_DEN_W = 11;
    localparam int SAT_NUM_W = 16;
    localparam int SAT_DEN_W = 8;

    // Side information that travels alongside the dividers
    typedef struct packed {
        logic       gray;
        logic       black;
        logic [7:0] mx;
    } side_t;

endpackage

FILE: rtl/core/r2h_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; used by the RGB to HSV converter top level.
module r2h_div_pipe #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 11,
    parameter int QUO_W = 9
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic [QUO_W-1:0] quo
);

    localparam int REM_W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [REM_W-1:0] rem_reg [QUO_W-1];
    logic [DEN_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    // One quotient bit per stage, most significant first
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        logic [REM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [REM_W-1:0] trial;
        logic             fits;

        if (j == 0) begin : g_first
            assign rem_in = REM_W'(numer);
            assign den_in = denom;
            assign quo_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign trial = REM_W'(den_in) << (QUO_W - 1 - j);
        assign fits  = (rem_in >= trial);

        // Advance quotient bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                quo_reg[j] <= quo_in | (fits ? (QUO_W'(1) << (QUO_W - 1 - j)) : '0);
            end
        end

        // Advance remainder and divisor to the next stage
        if (j < QUO_W - 1) begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j] <= fits ? (rem_in - trial) : rem_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

FILE: rtl/core/rgb_to_hsv_converter.sv
// RGB to HSV converter top level: stream ports, channel sort and the two dividers.
// Depends on r2h_pkg, r2h_div_pipe and rgb_to_hsv_converter_assert.svh.
//
// Converts one 8-bit RGB pixel per clock into 8-bit hue, saturation and value.
// From acceptance to presentation each item passes these stages: one stage sorts the
// channels, one forms numerators and divisors, nine run the two restoring dividers
// side by side (one quotient bit each), and one masks gray and black pixels into
// the output register. A new item is taken every cycle; when a result waits
// unaccepted on the output the whole pipeline holds, and s_tready drops with it.
module rgb_to_hsv_converter
    import r2h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] red, [15:8] green, [23:16] blue
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [7:0] hue, [15:8] saturation, [23:16] brightness_value
);

    `include "rgb_to_hsv_converter_assert.svh"

    localparam int PIPE_DEPTH = DIV_QUO_W + 3;

    logic                  en;
    logic [PIPE_DEPTH-1:0] valid_reg;

    logic [7:0]            red;
    logic [7:0]            green;
    logic [7:0]            blue;
    logic                  red_max;
    logic                  green_max;
    logic [7:0]            mx;
    logic [7:0]            mn;
    hue_sel_t              sel;
    logic signed [8:0]     num;

    logic [7:0]            a_mx_reg;
    logic [7:0]            a_delta_reg;
    logic signed [8:0]     a_num_reg;
    hue_sel_t              a_sel_reg;

    logic [10:0]           six_d;
    logic [11:0]           off_d;
    logic signed [12:0]    hue_sum;

    logic [HUE_NUM_W-1:0]  b_hue_num_reg;
    logic [HUE_DEN_W-1:0]  b_hue_den_reg;
    logic [SAT_NUM_W-1:0]  b_sat_num_reg;
    logic [SAT_DEN_W-1:0]  b_sat_den_reg;
    side_t                 b_side_reg;

    side_t                 side_reg [DIV_QUO_W];
    logic [DIV_QUO_W-1:0]  hue_quo;
    logic [DIV_QUO_W-1:0]  sat_quo;

    logic [7:0]            out_hue_reg;
    logic [7:0]            out_sat_reg;
    logic [7:0]            out_value_reg;

    // Hold everything while a result waits on the output
    assign en       = !valid_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = en;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // Sort channels and pick the hue sector
    assign red       = s_tdata[7:0];
    assign green     = s_tdata[15:8];
    assign blue      = s_tdata[23:16];
    assign red_max   = (red >= green) && (red >= blue);
    assign green_max = !red_max && (green >= blue);

    always_comb
    begin
        mn = (red < green) ? red : green;
        if (blue < mn)
        begin
            mn = blue;
        end
        if (red_max)
        begin
            sel = SEL_RED;
            mx  = red;
            num = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green_max)
        begin
            sel = SEL_GREEN;
            mx  = green;
            num = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sel = SEL_BLUE;
            mx  = blue;
            num = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mx_reg    <= mx;
            a_delta_reg <= mx - mn;
            a_num_reg   <= num;
            a_sel_reg   <= sel;
        end
    end

    // Form numerators and divisors: sector offset is (k + 6) * delta
    assign six_d = 11'({a_delta_reg, 2'b00}) + 11'({a_delta_reg, 1'b0});

    always_comb
    begin
        case (a_sel_reg)
            SEL_RED:   off_d = 12'(six_d);
            SEL_GREEN: off_d = 12'({a_delta_reg, 3'b000});
            SEL_BLUE:  off_d = 12'({a_delta_reg, 3'b000}) + 12'({a_delta_reg, 1'b0});
            default:   off_d = 12'(six_d);
        endcase
    end

    assign hue_sum = 13'(a_num_reg) + $signed({1'b0, off_d});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_hue_num_reg    <= {hue_sum[11:0], 8'h00};
            b_hue_den_reg    <= six_d;
            b_sat_num_reg    <= {a_delta_reg, 8'h00} - 16'(a_delta_reg);
            b_sat_den_reg    <= a_mx_reg;
            b_side_reg.gray  <= (a_delta_reg == 8'd0);
            b_side_reg.black <= (a_mx_reg == 8'd0);
            b_side_reg.mx    <= a_mx_reg;
        end
    end

    // Divide hue and saturation side by side
    r2h_div_pipe #(
        .NUM_W (HUE_NUM_W),
        .DEN_W (HUE_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_hue_div (
        .clk   (clk),
        .en    (en),
        .numer (b_hue_num_reg),
        .denom (b_hue_den_reg),
        .quo   (hue_quo)
    );

    r2h_div_pipe #(
        .NUM_W (SAT_NUM_W),
        .DEN_W (SAT_DEN_W),
        .QUO_W (DIV_QUO_W)
    ) u_sat_div (
        .clk   (clk),
        .en    (en),
        .numer (b_sat_num_reg),
        .denom (b_sat_den_reg),
        .quo   (sat_quo)
    );

    // Carry flags and value alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= b_side_reg;
            for (int j = 1; j < DIV_QUO_W; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // Drop quotients of gray and black pixels into the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hue_reg   <= side_reg[DIV_QUO_W-1].gray  ? 8'd0 : hue_quo[7:0];
            out_sat_reg   <= side_reg[DIV_QUO_W-1].black ? 8'd0 : sat_quo[7:0];
            out_value_reg <= side_reg[DIV_QUO_W-1].mx;
        end
    end

    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = {out_value_reg, out_sat_reg, out_hue_reg};

    // A saturated pixel has a nonzero delta, so zero saturation means gray
    `R2H_CHECK_OUT(a_gray_hue, (m_tdata[15:8] != 8'd0) || (m_tdata[7:0] == 8'd0),
        "zero saturation with nonzero hue")
    // A black pixel carries no saturation
    `R2H_CHECK_OUT(a_black_sat, (m_tdata[23:16] != 8'd0) || (m_tdata[15:8] == 8'd0),
        "black pixel with nonzero saturation")
    // Saturation quotient never exceeds eight bits for a lit pixel
    `R2H_CHECK(a_sat_range, valid_reg[PIPE_DEPTH-2] && !side_reg[DIV_QUO_W-1].black,
        !sat_quo[DIV_QUO_W-1], "saturation quotient overflow")

endmodule
